@@ src/small_matrix_inverse_assert.svh @@
// Assertion macros shared by the matrix inverter modules.
`ifndef SMALL_MATRIX_INVERSE_ASSERT_SVH
`define SMALL_MATRIX_INVERSE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SMI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/smi_pkg.sv @@
// Shared types, constants and helper functions of the matrix inverter.
`timescale 1ns / 1ps
package smi_pkg;

  localparam int MAX_SIZE_DEF   = 4;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int SIZE_W         = 3;
  localparam logic [SIZE_W-1:0] SIZE_RST = 3'd4;
  localparam int LIMB_W         = 32;

  typedef struct packed {
    logic              bank;
    logic [SIZE_W-1:0] n;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef struct packed {
    logic            odd;
    logic [3:0][1:0] p;
  } perm_t;

  // Size register to effective dimension.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s,
                                                   input int unsigned mx);
    logic [SIZE_W-1:0] r;
    if (s == '0) r = SIZE_W'(1);
    else if (32'(s) > mx) r = SIZE_W'(mx);
    else r = s;
    return r;
  endfunction

  // Permutations of four, ordered so the first k! fix positions k and up.
  function automatic perm_t perm_map(input logic [2:0] base, input logic [1:0] swp);
    perm_t     r;
    logic [1:0] tmp;
    logic [1:0] k;
    case (base)
      3'd0:    begin r.p = {2'd3, 2'd2, 2'd1, 2'd0}; r.odd = 1'b0; end
      3'd1:    begin r.p = {2'd3, 2'd2, 2'd0, 2'd1}; r.odd = 1'b1; end
      3'd2:    begin r.p = {2'd3, 2'd1, 2'd2, 2'd0}; r.odd = 1'b1; end
      3'd3:    begin r.p = {2'd3, 2'd0, 2'd2, 2'd1}; r.odd = 1'b0; end
      3'd4:    begin r.p = {2'd3, 2'd1, 2'd0, 2'd2}; r.odd = 1'b0; end
      3'd5:    begin r.p = {2'd3, 2'd0, 2'd1, 2'd2}; r.odd = 1'b1; end
      default: begin r.p = {2'd3, 2'd2, 2'd1, 2'd0}; r.odd = 1'b0; end
    endcase
    if (swp != 2'd0) begin
      k = swp - 2'd1;
      tmp = r.p[k];
      r.p[k] = r.p[3];
      r.p[3] = tmp;
      r.odd = ~r.odd;
    end
    return r;
  endfunction

endpackage

@@ src/smi_queue.sv @@
// Two-entry job queue between the load front and the compute back.
`timescale 1ns / 1ps
`include "small_matrix_inverse_assert.svh"
module smi_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  smi_pkg::job_t push_job,
  input  logic          pop,
  output logic          q_valid,
  output smi_pkg::job_t q_job
);
  import smi_pkg::*;

  job_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  `SMI_ASSERT_IMPL(a_no_overflow, push, cnt_r != 2'd2, "job queue pushed while full")
  `SMI_ASSERT_IMPL(a_no_underflow, pop, cnt_r != 2'd0, "job queue popped while empty")
  `SMI_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r != 2'd3, "job queue count out of range")

endmodule

@@ src/smi_front.sv @@
// Load front: size register, element counting and bank handoff.
`timescale 1ns / 1ps
module smi_front #(
  parameter int MAX_SIZE   = smi_pkg::MAX_SIZE_DEF,
  parameter int ELEM_WIDTH = smi_pkg::ELEM_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [ELEM_WIDTH-1:0]                   elem,
  input  logic                                    cfg_wr_en,
  input  logic [smi_pkg::SIZE_W-1:0]              cfg_wr_data,
  input  smi_pkg::rel_t                           rel,
  output logic                                    push,
  output smi_pkg::job_t                           push_job,
  output logic                                    wr_en,
  output logic [$clog2(2*MAX_SIZE*MAX_SIZE)-1:0]  wr_idx,
  output logic [ELEM_WIDTH-1:0]                   wr_data
);
  import smi_pkg::*;

  localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int MI_W  = $clog2(2*MAX_SIZE*MAX_SIZE);

  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] n;
  logic [IDX_W-1:0]  row_r;
  logic [IDX_W-1:0]  col_r;
  logic              wb_r;
  logic [1:0]        busy_r;
  logic              acc;
  logic              row_end;
  logic              col_end;

  assign n         = clamp_size(size_r, MAX_SIZE);
  assign in_tready = ~busy_r[wb_r];
  assign acc       = in_tvalid & in_tready;
  assign col_end   = (col_r == IDX_W'(n - SIZE_W'(1)));
  assign row_end   = (row_r == IDX_W'(n - SIZE_W'(1)));

  assign wr_en   = acc;
  assign wr_data = elem;
  assign wr_idx  = MI_W'(row_r) * MI_W'(MAX_SIZE) + MI_W'(col_r)
                 + (wb_r ? MI_W'(MAX_SIZE*MAX_SIZE) : MI_W'(0));

  assign push          = acc & col_end & row_end;
  assign push_job.bank = wb_r;
  assign push_job.n    = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RST;
      row_r  <= '0;
      col_r  <= '0;
      wb_r   <= 1'b0;
      busy_r <= 2'b00;
    end else begin
      // A size write drops any partly loaded matrix.
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
        row_r  <= '0;
        col_r  <= '0;
      end else if (acc) begin
        if (col_end) begin
          col_r <= '0;
          row_r <= row_end ? '0 : row_r + IDX_W'(1);
        end else begin
          col_r <= col_r + IDX_W'(1);
        end
      end
      if (push) wb_r <= ~wb_r;
      if (rel.valid) busy_r[rel.bank] <= 1'b0;
      if (push) busy_r[wb_r] <= 1'b1;
    end
  end

endmodule

@@ src/smi_back.sv @@
// Compute back: element store, cofactor engine, divider and result register.
`timescale 1ns / 1ps
`include "small_matrix_inverse_assert.svh"
module smi_back #(
  parameter int MAX_SIZE   = smi_pkg::MAX_SIZE_DEF,
  parameter int FRAC_BITS  = smi_pkg::FRAC_BITS_DEF,
  parameter int ELEM_WIDTH = smi_pkg::ELEM_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   wr_en,
  input  logic [$clog2(2*MAX_SIZE*MAX_SIZE)-1:0] wr_idx,
  input  logic [ELEM_WIDTH-1:0]                  wr_data,
  input  logic                                   q_valid,
  input  smi_pkg::job_t                          q_job,
  output logic                                   q_pop,
  output smi_pkg::rel_t                          rel,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((ELEM_WIDTH+7)/8)*8-1:0]        out_tdata,
  output logic [1:0]                             out_tuser,
  output logic                                   out_tlast
);
  import smi_pkg::*;

  localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int CNT_W  = $clog2(MAX_SIZE + 1);
  localparam int MI_W   = $clog2(2*MAX_SIZE*MAX_SIZE);
  localparam int PROD_W = MAX_SIZE*(ELEM_WIDTH-1) + 1;
  localparam int NL     = (PROD_W + LIMB_W - 1) / LIMB_W;
  localparam int Q_W    = NL*LIMB_W;
  localparam int K_W    = $clog2(NL + 1);
  localparam int DET_W  = Q_W + 6;
  localparam int DIV_W  = DET_W + 2*FRAC_BITS + ELEM_WIDTH + 1;
  localparam int B_W    = $clog2(ELEM_WIDTH);
  localparam int PP_W   = LIMB_W + ELEM_WIDTH;
  localparam int TD_W   = ((ELEM_WIDTH+7)/8)*8;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_ACC  = 9'b000001000,
    S_DET  = 9'b000010000,
    S_DCHK = 9'b000100000,
    S_OVF  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  logic [ELEM_WIDTH-1:0] mem [2*MAX_SIZE*MAX_SIZE];
  logic [ELEM_WIDTH-1:0] rd_data_r;
  logic                  rd_en;
  logic [MI_W-1:0]       rd_idx;

  state_t                  state_r;
  logic                    bank_r;
  logic [SIZE_W-1:0]       n_r;
  logic [CNT_W-1:0]        m_r;
  logic                    cof_r;
  logic                    sing_r;
  logic [IDX_W-1:0]        i_r;
  logic [IDX_W-1:0]        j_r;
  logic [CNT_W-1:0]        t_r;
  logic [2:0]              base_r;
  logic [1:0]              swp_r;
  logic                    psign_r;
  logic [Q_W-1:0]          p_r;
  logic [Q_W-1:0]          q_acc_r;
  logic [K_W-1:0]          k_r;
  logic [K_W-1:0]          kd_r;
  logic [PP_W-1:0]         pp_r;
  logic                    ppv_r;
  logic signed [DET_W-1:0] acc_r;
  logic [DET_W-1:0]        det_mag_r;
  logic                    det_neg_r;
  logic [DIV_W-1:0]        rem_r;
  logic [DIV_W-1:0]        ds_r;
  logic [ELEM_WIDTH-1:0]   quo_r;
  logic [B_W-1:0]          bcnt_r;
  logic                    qneg_r;
  logic                    ovf_r;

  logic                    out_tvalid_r;
  logic [ELEM_WIDTH-1:0]   out_val_r;
  logic                    out_sat_r;
  logic                    out_sing_r;
  logic                    out_last_r;

  perm_t                   pm;
  logic [CNT_W-1:0]        row_c;
  logic [CNT_W-1:0]        col_c;
  logic [CNT_W-1:0]        pcol;
  logic [ELEM_WIDTH-1:0]   emag;
  logic [LIMB_W-1:0]       limb;
  logic signed [DET_W-1:0] pterm;
  logic signed [DET_W-1:0] acc_sum;
  logic [2:0]              base_last;
  logic [1:0]              swp_last;
  logic                    perm_done;
  logic                    mul_done;
  logic                    out_free;
  logic                    j_end;
  logic                    i_end;
  logic                    ovf_c;
  logic                    ge_c;
  logic [CNT_W-1:0]        m_cof;
  logic [ELEM_WIDTH-1:0]   res_val;
  logic                    res_sat;
  logic [ELEM_WIDTH-1:0]   pos_max;
  logic [ELEM_WIDTH-1:0]   neg_min;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_idx];
  end

  assign pm    = perm_map(base_r, swp_r);
  assign pcol  = CNT_W'(pm.p[2'(t_r)]);
  assign row_c = (cof_r && t_r >= CNT_W'(j_r)) ? t_r + CNT_W'(1) : t_r;
  assign col_c = (cof_r && pcol >= CNT_W'(i_r)) ? pcol + CNT_W'(1) : pcol;
  assign rd_en = (state_r == S_RD);
  assign rd_idx = MI_W'(row_c) * MI_W'(MAX_SIZE) + MI_W'(col_c)
                + (bank_r ? MI_W'(MAX_SIZE*MAX_SIZE) : MI_W'(0));

  assign emag     = rd_data_r[ELEM_WIDTH-1] ? -rd_data_r : rd_data_r;
  assign limb     = p_r[LIMB_W*k_r +: LIMB_W];
  assign mul_done = (k_r == K_W'(NL)) && !ppv_r;

  assign pterm   = $signed(DET_W'(p_r));
  assign acc_sum = acc_r + ((psign_r ^ pm.odd) ? -pterm : pterm);

  always_comb begin
    if (32'(m_r) <= 1) base_last = 3'd0;
    else if (32'(m_r) == 2) base_last = 3'd1;
    else base_last = 3'd5;
    swp_last = (32'(m_r) >= 4) ? 2'd3 : 2'd0;
  end
  assign perm_done = (base_r == base_last) && (swp_r == swp_last);

  assign out_free = !out_tvalid_r || out_tready;
  assign j_end    = (j_r == IDX_W'(n_r - SIZE_W'(1)));
  assign i_end    = (i_r == IDX_W'(n_r - SIZE_W'(1)));
  assign m_cof    = CNT_W'(n_r - SIZE_W'(1));
  assign ovf_c    = rem_r >= (DIV_W'(det_mag_r) << ELEM_WIDTH);
  assign ge_c     = rem_r >= ds_r;

  assign pos_max = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  assign neg_min = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

  always_comb begin
    res_val = '0;
    res_sat = 1'b0;
    if (sing_r) begin
      res_val = '0;
    end else if (ovf_r) begin
      res_sat = 1'b1;
      res_val = qneg_r ? neg_min : pos_max;
    end else if (qneg_r) begin
      if (quo_r > neg_min) begin
        res_sat = 1'b1;
        res_val = neg_min;
      end else begin
        res_val = -quo_r;
      end
    end else if (quo_r > pos_max) begin
      res_sat = 1'b1;
      res_val = pos_max;
    end else begin
      res_val = quo_r;
    end
  end

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign rel.valid = (state_r == S_OUT) && out_free && i_end && j_end;
  assign rel.bank  = bank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            bank_r  <= q_job.bank;
            n_r     <= q_job.n;
            m_r     <= CNT_W'(q_job.n);
            cof_r   <= 1'b0;
            sing_r  <= 1'b0;
            acc_r   <= '0;
            base_r  <= 3'd0;
            swp_r   <= 2'd0;
            p_r     <= Q_W'(1);
            t_r     <= '0;
            psign_r <= 1'b0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          k_r     <= '0;
          ppv_r   <= 1'b0;
          q_acc_r <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          // One limb of the running product times the element per cycle.
          if (ppv_r) q_acc_r <= q_acc_r + (Q_W'(pp_r) << (LIMB_W*kd_r));
          if (k_r != K_W'(NL)) begin
            pp_r  <= PP_W'(limb) * PP_W'(emag);
            kd_r  <= k_r;
            ppv_r <= 1'b1;
            k_r   <= k_r + K_W'(1);
          end else begin
            ppv_r <= 1'b0;
          end
          if (mul_done) begin
            p_r     <= q_acc_r;
            psign_r <= psign_r ^ rd_data_r[ELEM_WIDTH-1];
            t_r     <= t_r + CNT_W'(1);
            state_r <= (t_r + CNT_W'(1) == m_r) ? S_ACC : S_RD;
          end
        end
        S_ACC: begin
          acc_r <= acc_sum;
          if (perm_done) begin
            state_r <= cof_r ? S_DCHK : S_DET;
          end else begin
            if (base_r == base_last) begin
              base_r <= 3'd0;
              swp_r  <= swp_r + 2'd1;
            end else begin
              base_r <= base_r + 3'd1;
            end
            p_r     <= Q_W'(1);
            t_r     <= '0;
            psign_r <= 1'b0;
            state_r <= S_RD;
          end
        end
        S_DET: begin
          det_neg_r <= acc_r[DET_W-1];
          det_mag_r <= acc_r[DET_W-1] ? DET_W'(-acc_r) : DET_W'(acc_r);
          i_r <= '0;
          j_r <= '0;
          if (acc_r == '0) begin
            sing_r  <= 1'b1;
            state_r <= S_OUT;
          end else begin
            cof_r   <= 1'b1;
            m_r     <= m_cof;
            acc_r   <= '0;
            base_r  <= 3'd0;
            swp_r   <= 2'd0;
            p_r     <= Q_W'(1);
            t_r     <= '0;
            psign_r <= 1'b0;
            state_r <= (m_cof == '0) ? S_ACC : S_RD;
          end
        end
        S_DCHK: begin
          qneg_r <= acc_r[DET_W-1] ^ det_neg_r ^ i_r[0] ^ j_r[0];
          rem_r  <= DIV_W'(acc_r[DET_W-1] ? DET_W'(-acc_r) : DET_W'(acc_r))
                    << (2*FRAC_BITS);
          state_r <= S_OVF;
        end
        S_OVF: begin
          ovf_r   <= ovf_c;
          ds_r    <= DIV_W'(det_mag_r) << (ELEM_WIDTH-1);
          bcnt_r  <= B_W'(ELEM_WIDTH-1);
          quo_r   <= '0;
          state_r <= ovf_c ? S_OUT : S_DIV;
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (ge_c) rem_r <= rem_r - ds_r;
          quo_r  <= {quo_r[ELEM_WIDTH-2:0], ge_c};
          ds_r   <= ds_r >> 1;
          bcnt_r <= bcnt_r - B_W'(1);
          if (bcnt_r == '0) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            if (i_end && j_end) begin
              state_r <= S_IDLE;
            end else begin
              if (j_end) begin
                j_r <= '0;
                i_r <= i_r + IDX_W'(1);
              end else begin
                j_r <= j_r + IDX_W'(1);
              end
              if (!sing_r) begin
                acc_r   <= '0;
                base_r  <= 3'd0;
                swp_r   <= 2'd0;
                p_r     <= Q_W'(1);
                t_r     <= '0;
                psign_r <= 1'b0;
                state_r <= (m_r == '0) ? S_ACC : S_RD;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result register: holds one item while the back works on the next.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_val_r  <= res_val;
      out_sat_r  <= res_sat;
      out_sing_r <= sing_r;
      out_last_r <= i_end && j_end;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = TD_W'(out_val_r);
  assign out_tuser  = {out_sing_r, out_sat_r};
  assign out_tlast  = out_last_r;

  `SMI_ASSERT_IMPL(a_div_den, state_r == S_DIV, ds_r != '0, "division by zero determinant")
  `SMI_ASSERT_NEXT(a_rel_idle, rel.valid, state_r == S_IDLE, "bank released mid-job")
  `SMI_ASSERT_IMPL(a_state_onehot, 1'b1, $onehot(state_r), "state not one-hot")
  `SMI_ASSERT_NEXT(a_out_hold, out_tvalid_r && !out_tready, out_tvalid_r && $stable(out_val_r), "result item changed while stalled")

endmodule

@@ src/small_matrix_inverse.sv @@
// Top level of the small square matrix inverter (adjugate method, fixed point).
//
// channel  dir  handshake              payload
// in       in   in_tvalid/in_tready    in_tdata: element_value
// out      out  out_tvalid/out_tready  out_tdata: inverse_value; out_tuser; out_tlast
// cfg      in   cfg_wr_en              cfg_wr_data: matrix_size
//
// Loading takes one element a cycle while in_tready is high, into one of two banks
// of the element store. Each matrix then takes a determinant pass and, unless the
// determinant is zero, a cofactor pass for each of the n*n results, followed by a
// division unless it overflows; the time is set by the shared limb multiplier
// over the limbs of the product register (4 by default) and the bit-per-cycle divider.
// Reset: synchronous, active low; size returns to 4, no clearing pass.
// in_tready drops while both banks hold matrices; out_tready stalls the back only.
`timescale 1ns / 1ps
module small_matrix_inverse #(
  parameter int MAX_SIZE   = smi_pkg::MAX_SIZE_DEF,
  parameter int FRAC_BITS  = smi_pkg::FRAC_BITS_DEF,
  parameter int ELEM_WIDTH = smi_pkg::ELEM_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [((ELEM_WIDTH+7)/8)*8-1:0]  in_tdata,   // element_value
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [((ELEM_WIDTH+7)/8)*8-1:0]  out_tdata,  // inverse_value
  output logic [1:0]                       out_tuser,  // singular (bit 1), saturated (bit 0)
  output logic                             out_tlast,  // last_of_matrix
  input  logic                             cfg_wr_en,
  input  logic [smi_pkg::SIZE_W-1:0]       cfg_wr_data // matrix_size
);
  import smi_pkg::*;

  localparam int MI_W = $clog2(2*MAX_SIZE*MAX_SIZE);

  rel_t                  rel;
  job_t                  push_job;
  job_t                  q_job;
  logic                  push;
  logic                  q_valid;
  logic                  q_pop;
  logic                  wr_en;
  logic [MI_W-1:0]       wr_idx;
  logic [ELEM_WIDTH-1:0] wr_data;

  smi_front #(
    .MAX_SIZE   (MAX_SIZE),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .elem        (in_tdata[ELEM_WIDTH-1:0]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rel         (rel),
    .push        (push),
    .push_job    (push_job),
    .wr_en       (wr_en),
    .wr_idx      (wr_idx),
    .wr_data     (wr_data)
  );

  smi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  smi_back #(
    .MAX_SIZE   (MAX_SIZE),
    .FRAC_BITS  (FRAC_BITS),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_idx     (wr_idx),
    .wr_data    (wr_data),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .q_pop      (q_pop),
    .rel        (rel),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
